FILE: rtl/bitmap_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// bitmap_block_allocator_macros
// concurrent assertion macros for the allocator
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
// property that holds whenever reset is released
`define BBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// property that holds at every edge, reset included
`define BBA_ASSERT_ALL(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and codes of the bitmap block allocator
// ----------------------------------------------------------------------------
`default_nettype none
package bba_pkg;
	localparam logic [2:0] CMD_REINIT    = 3'd0;
	localparam logic [2:0] CMD_ALLOC_ONE = 3'd1;
	localparam logic [2:0] CMD_ALLOC_RUN = 3'd2;
	localparam logic [2:0] CMD_FREE_ONE  = 3'd3;
	localparam logic [2:0] CMD_FREE_RNG  = 3'd4;
	localparam logic [2:0] CMD_MARK_RNG  = 3'd5;
	localparam logic [2:0] CMD_QUERY     = 3'd6;
	localparam logic [2:0] CMD_RSVD      = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;
	// internal marker while a reinit sweeps the map
	localparam logic [1:0] ST_SWEEP   = 2'd3;

	localparam logic CFG_TOTAL = 1'b0;
	localparam logic CFG_FIRST = 1'b1;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [11:0] block_index;
		logic [12:0] count;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] result_block;
		logic        is_allocated;
		logic [12:0] used_count;
		logic [12:0] free_count;
	} res_word_t;
endpackage
`default_nettype wire

FILE: rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator: a rejected word or empty range goes straight to done, query reads a
// block, free one clears it, alloc one sets the first free block from the hint, alloc run finds
// a free run then sets it, ranges write each block, reinit sweeps; next word at the edge ending
// the done cycle, results never stall; reset async, map swept with busy high
// ----------------------------------------------------------------------------
`default_nettype none
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire bba_pkg::cmd_word_t request,
	output logic                    done,
	output bba_pkg::res_word_t      result,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [12:0]        cfg_data
);
	`include "bitmap_block_allocator_macros.svh"

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int CW = (AW + 2 > 14) ? AW + 2 : 14;
	localparam logic [CW-1:0] NB = CW'(NUM_BLOCKS);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_MARK, S_DONE} state_t;

	state_t        state_q;
	logic [12:0]   total_q;
	logic [11:0]   first_q;
	logic [CW-1:0] used_q, hint_q, pos_q, run_q, start_q, end_q, res_q;
	logic          wrap_q, pass2_q;
	logic [2:0]    cmd_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    status_q;
	logic          isal_q;

	logic          rdata, we, wdata;
	logic [AW-1:0] raddr, waddr;
	logic [CW-1:0] tot;

	assign tot = (CW'(total_q) < NB) ? CW'(total_q) : NB;

	bba_map_mem #(.DEPTH(NUM_BLOCKS), .AW(AW)) u_map (
		.clk(clk), .raddr(raddr), .rdata(rdata),
		.we(we), .waddr(waddr), .wdata(wdata)
	);

	assign raddr = pos_q[AW-1:0];
	assign waddr = pos_q[AW-1:0];
	assign busy  = (state_q != S_IDLE);

	always_comb begin
		we = 1'b0;
		wdata = 1'b0;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
		end else if (state_q == S_MARK) begin
			we = 1'b1;
			wdata = (cmd_q != bba_pkg::CMD_FREE_RNG) && (cmd_q != bba_pkg::CMD_FREE_ONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 13'd4096;
			first_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == bba_pkg::CFG_TOTAL) begin
				total_q <= cfg_data;
			end else begin
				first_q <= cfg_data[11:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			used_q <= '0; hint_q <= '0; pos_q <= '0; run_q <= '0;
			start_q <= '0; end_q <= '0; res_q <= '0;
			wrap_q <= 1'b0; pass2_q <= 1'b0; cmd_q <= '0;
			cnt_q <= '0; status_q <= '0; isal_q <= 1'b0;
			done <= 1'b0; result <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == NB - 1'b1) begin
						state_q <= (cmd_q == bba_pkg::CMD_REINIT
							&& status_q == bba_pkg::ST_SWEEP) ? S_DONE : S_IDLE;
						status_q <= bba_pkg::ST_OK;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q <= request.cmd;
						cnt_q <= CW'(request.count);
						status_q <= bba_pkg::ST_OK;
						isal_q <= 1'b0;
						res_q <= '0;
						run_q <= '0;
						pass2_q <= 1'b0;
						state_q <= S_DONE;
						case (request.cmd)
							bba_pkg::CMD_REINIT: begin
								used_q <= '0;
								hint_q <= CW'(first_q);
								pos_q <= '0;
								status_q <= bba_pkg::ST_SWEEP;
								state_q <= S_CLEAR;
							end
							bba_pkg::CMD_ALLOC_ONE: begin
								if (used_q >= tot) begin
									status_q <= bba_pkg::ST_NOSPACE;
								end else begin
									start_q <= (hint_q < tot) ? hint_q : tot;
									pos_q <= (hint_q < tot) ? hint_q : '0;
									wrap_q <= !(hint_q < tot);
									state_q <= S_READ;
								end
							end
							bba_pkg::CMD_ALLOC_RUN: begin
								if (request.count == '0) begin
									status_q <= bba_pkg::ST_INVALID;
								end else if (used_q + CW'(request.count) > tot) begin
									status_q <= bba_pkg::ST_NOSPACE;
								end else begin
									pos_q <= '0;
									state_q <= S_READ;
								end
							end
							bba_pkg::CMD_FREE_ONE, bba_pkg::CMD_QUERY: begin
								if (CW'(request.block_index) >= tot) begin
									status_q <= bba_pkg::ST_INVALID;
								end else begin
									pos_q <= CW'(request.block_index);
									state_q <= S_READ;
								end
							end
							bba_pkg::CMD_FREE_RNG, bba_pkg::CMD_MARK_RNG: begin
								if (CW'(request.block_index) + CW'(request.count) > tot) begin
									status_q <= bba_pkg::ST_INVALID;
								end else begin
									pos_q <= CW'(request.block_index);
									end_q <= CW'(request.block_index) + CW'(request.count);
									if (request.cmd == bba_pkg::CMD_FREE_RNG
										&& CW'(request.block_index) < hint_q) begin
										hint_q <= CW'(request.block_index);
									end
									if (request.count != '0) begin
										state_q <= S_READ;
									end
								end
							end
							default: status_q <= bba_pkg::ST_INVALID;
						endcase
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					state_q <= S_READ;
					case (cmd_q)
						bba_pkg::CMD_ALLOC_ONE: begin
							if (!rdata) begin
								res_q <= pos_q;
								used_q <= used_q + 1'b1;
								hint_q <= pos_q + 1'b1;
								state_q <= S_MARK;
							end else if (!wrap_q && pos_q + 1'b1 < tot) begin
								pos_q <= pos_q + 1'b1;
							end else if (!wrap_q) begin
								wrap_q <= 1'b1;
								pos_q <= '0;
								if (start_q == '0) begin
									status_q <= bba_pkg::ST_NOSPACE;
									state_q <= S_DONE;
								end
							end else if (pos_q + 1'b1 < start_q) begin
								pos_q <= pos_q + 1'b1;
							end else begin
								status_q <= bba_pkg::ST_NOSPACE;
								state_q <= S_DONE;
							end
						end
						bba_pkg::CMD_ALLOC_RUN: begin
							if (!pass2_q) begin
								if (!rdata && run_q + 1'b1 == cnt_q) begin
									res_q <= pos_q + 1'b1 - cnt_q;
									pos_q <= pos_q + 1'b1 - cnt_q;
									end_q <= pos_q + 1'b1;
									hint_q <= pos_q + 1'b1;
									pass2_q <= 1'b1;
								end else if (pos_q + 1'b1 < tot) begin
									run_q <= rdata ? '0 : run_q + 1'b1;
									pos_q <= pos_q + 1'b1;
								end else begin
									status_q <= bba_pkg::ST_NOSPACE;
									state_q <= S_DONE;
								end
							end else begin
								if (!rdata) used_q <= used_q + 1'b1;
								state_q <= S_MARK;
							end
						end
						bba_pkg::CMD_QUERY: begin
							isal_q <= rdata;
							state_q <= S_DONE;
						end
						bba_pkg::CMD_FREE_ONE: begin
							if (!rdata) begin
								status_q <= bba_pkg::ST_INVALID;
								state_q <= S_DONE;
							end else begin
								used_q <= used_q - 1'b1;
								if (pos_q < hint_q) hint_q <= pos_q;
								state_q <= S_MARK;
							end
						end
						bba_pkg::CMD_FREE_RNG: begin
							if (rdata && used_q != '0) used_q <= used_q - 1'b1;
							state_q <= S_MARK;
						end
						default: begin
							if (!rdata) used_q <= used_q + 1'b1;
							state_q <= S_MARK;
						end
					endcase
				end
				S_MARK: begin
					if ((cmd_q == bba_pkg::CMD_ALLOC_ONE) || (cmd_q == bba_pkg::CMD_FREE_ONE)
						|| (pos_q + 1'b1 >= end_q)) begin
						state_q <= S_DONE;
					end else begin
						pos_q <= pos_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					done <= 1'b1;
					result.status <= status_q;
					result.result_block <= (status_q == bba_pkg::ST_OK) ? res_q[11:0] : '0;
					result.is_allocated <= isal_q;
					result.used_count <= used_q[12:0];
					result.free_count <= (tot > used_q) ? 13'(tot - used_q) : '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BBA_ASSERT(a_done_pulse, done |=> !done, "done longer than one cycle")
	`BBA_ASSERT(a_done_from_busy, done |-> $past(busy), "result without command")
	`BBA_ASSERT(a_ok_status, done |-> (result.status <= bba_pkg::ST_NOSPACE), "bad status code")
	`BBA_ASSERT_ALL(a_quiet_in_reset, !arst_n |=> !done, "result during reset")
endmodule
`default_nettype wire

FILE: rtl/bba_map_mem.sv
// ----------------------------------------------------------------------------
// bba_map_mem
// one-bit-per-block used map, synchronous (registered) read
// ----------------------------------------------------------------------------
`default_nettype none
module bba_map_mem #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  wire logic          clk,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wdata
);
	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
